FILE: sv/uflre_pkg.sv
// uflre_pkg: shared types, widths and codes for the uart frame run-length encoder
// depends on nothing; every module of the block refers to it by scoped names

package uflre_pkg;

  // frame geometry
  localparam int DATA_BITS = 8;
  localparam int FRAME_MAX = DATA_BITS + 3;                 // start, data, parity, stop
  localparam int LEN_W     = $clog2(FRAME_MAX + 1);
  localparam int EXTRA_W   = 2;                             // extra stop half-bits, 0..2
  localparam int UNITS_W   = $clog2(2 * FRAME_MAX + 3);     // half-bit units of one run
  localparam int TICKS_W   = 16;
  localparam int PROD_W    = UNITS_W + TICKS_W;
  localparam int DUR_W     = 21;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 2'd2;

  // parity codes
  localparam logic [1:0] PARITY_NONE = 2'd0;
  localparam logic [1:0] PARITY_EVEN = 2'd1;
  localparam logic [1:0] PARITY_ODD  = 2'd2;

  // stop length codes
  localparam logic [1:0] STOP_ONE      = 2'd0;
  localparam logic [1:0] STOP_ONE_HALF = 2'd1;
  localparam logic [1:0] STOP_TWO      = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic             line_level;
    logic [DUR_W-1:0] duration_ticks;
    logic             frame_last;
    logic             message_end;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         parity_mode;
    logic [1:0]         stop_length;
    logic [TICKS_W-1:0] half_bit_ticks;   // already forced to at least one
  } cfg_t;

  // one framed byte, position 0 goes on the line first
  typedef struct packed {
    logic [FRAME_MAX-1:0] bits;
    logic [LEN_W-1:0]     len;
    logic [EXTRA_W-1:0]   extra;
    logic                 last_byte;
  } frame_t;

  // one merged run in half-bit units
  typedef struct packed {
    logic               level;
    logic [UNITS_W-1:0] units;
    logic               frame_last;
    logic               message_end;
  } run_t;

endpackage

FILE: sv/uflre_frame.sv
// uflre_frame: first stage, builds the bit frame of one byte and holds it
// depends on uflre_pkg

module uflre_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uflre_pkg::in_word_t in_word,
  input  uflre_pkg::cfg_t     cfg,
  output logic                frame_valid,
  input  logic                frame_ready,
  output uflre_pkg::frame_t   frame
);

  logic                          valid_r;
  uflre_pkg::frame_t             frame_r;
  uflre_pkg::frame_t             frame_nxt;
  logic [uflre_pkg::DATA_BITS-1:0] data_ext;
  logic                          par_on;
  logic                          par_bit;

  assign in_ready    = !valid_r || frame_ready;
  assign frame_valid = valid_r;
  assign frame       = frame_r;

  // frame layout: low start, data lsb first, optional parity, high stop
  always_comb begin
    data_ext = uflre_pkg::DATA_BITS'(in_word.data_byte);
    par_on   = 1'b0;
    par_bit  = 1'b0;
    unique case (cfg.parity_mode)
      uflre_pkg::PARITY_EVEN: begin
        par_on  = 1'b1;
        par_bit = ^data_ext;
      end
      uflre_pkg::PARITY_ODD: begin
        par_on  = 1'b1;
        par_bit = ~(^data_ext);
      end
      default: begin
        par_on  = 1'b0;
        par_bit = 1'b0;
      end
    endcase

    frame_nxt.bits    = '1;
    frame_nxt.bits[0] = 1'b0;
    for (int j = 0; j < uflre_pkg::DATA_BITS; j++) begin
      frame_nxt.bits[1 + j] = data_ext[j];
    end
    frame_nxt.bits[uflre_pkg::DATA_BITS + 1] = par_on ? par_bit : 1'b1;
    frame_nxt.len = par_on ? uflre_pkg::LEN_W'(uflre_pkg::FRAME_MAX)
                           : uflre_pkg::LEN_W'(uflre_pkg::FRAME_MAX - 1);

    unique case (cfg.stop_length)
      uflre_pkg::STOP_ONE_HALF: frame_nxt.extra = uflre_pkg::EXTRA_W'(1);
      uflre_pkg::STOP_TWO:      frame_nxt.extra = uflre_pkg::EXTRA_W'(2);
      default:                  frame_nxt.extra = '0;
    endcase
    frame_nxt.last_byte = in_word.last_byte;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r <= frame_nxt;
    end
  end

endmodule

FILE: sv/uflre_runs.sv
// uflre_runs: second stage, peels one run of equal bits off the frame per cycle while its run output is not stalled
// depends on uflre_pkg

module uflre_runs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_valid,
  output logic              frame_ready,
  input  uflre_pkg::frame_t frame,
  output logic              run_valid,
  input  logic              run_take,
  output uflre_pkg::run_t   run
);

  logic                           busy_r;
  logic [uflre_pkg::FRAME_MAX-1:0] bits_r;
  logic [uflre_pkg::LEN_W-1:0]     len_r;
  logic [uflre_pkg::EXTRA_W-1:0]   extra_r;
  logic                           last_r;
  logic                           run_valid_r;
  uflre_pkg::run_t                run_r;
  uflre_pkg::run_t                run_nxt;

  logic                       going;
  logic [uflre_pkg::LEN_W-1:0] cnt;
  logic                       fl;
  logic                       emit;
  logic                       load;

  // length of the run at the bottom of the remaining frame
  always_comb begin
    going = 1'b1;
    cnt   = '0;
    for (int i = 0; i < uflre_pkg::FRAME_MAX; i++) begin
      if (going && (bits_r[i] == bits_r[0]) && (uflre_pkg::LEN_W'(i) < len_r)) begin
        cnt = cnt + 1'b1;
      end else begin
        going = 1'b0;
      end
    end
    fl = (cnt == len_r);
    run_nxt.level       = bits_r[0];
    run_nxt.units       = uflre_pkg::UNITS_W'({cnt, 1'b0})
                        + uflre_pkg::UNITS_W'(fl ? extra_r : '0);
    run_nxt.frame_last  = fl;
    run_nxt.message_end = fl && last_r;
  end

  assign emit        = busy_r && (!run_valid_r || run_take);
  assign frame_ready = !busy_r || (emit && fl);
  assign load        = frame_valid && frame_ready;
  assign run_valid   = run_valid_r;
  assign run         = run_r;

  // control: busy flag and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      run_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && fl) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        run_valid_r <= 1'b1;
      end else if (run_take) begin
        run_valid_r <= 1'b0;
      end
    end
  end

  // remaining frame and emitted run
  always_ff @(posedge clk) begin
    if (load) begin
      bits_r  <= frame.bits;
      len_r   <= frame.len;
      extra_r <= frame.extra;
      last_r  <= frame.last_byte;
    end else if (emit) begin
      bits_r <= bits_r >> cnt;
      len_r  <= len_r - cnt;
    end
    if (emit) begin
      run_r <= run_nxt;
    end
  end

endmodule

FILE: sv/uflre_scale.sv
// uflre_scale: last stage, scales run units by the half-bit tick count into the output register
// depends on uflre_pkg

module uflre_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          run_valid,
  output logic                          run_take,
  input  uflre_pkg::run_t               run,
  input  logic [uflre_pkg::TICKS_W-1:0] ticks,
  output logic                          out_valid,
  input  logic                          out_ready,
  output uflre_pkg::out_word_t          out_word
);

  logic                          out_valid_r;
  uflre_pkg::out_word_t          out_word_r;
  uflre_pkg::out_word_t          out_word_nxt;
  logic [uflre_pkg::PROD_W-1:0]  prod;

  assign run_take  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // duration in ticks
  always_comb begin
    prod = uflre_pkg::PROD_W'(run.units) * uflre_pkg::PROD_W'(ticks);
    out_word_nxt.line_level     = run.level;
    out_word_nxt.duration_ticks = uflre_pkg::DUR_W'(prod);
    out_word_nxt.frame_last     = run.frame_last;
    out_word_nxt.message_end    = run.message_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (run_take) begin
      out_valid_r <= run_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run_take && run_valid) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

FILE: sv/uart_frame_run_length_encoder.sv
// uart_frame_run_length_encoder: three-stage frame, run and scale pipeline
// an accepted word goes from the frame register into the run stage; its runs pass the run and output registers
// throughput: one run per cycle while the output is not stalled; a byte gives as many runs
//   as its frame has (two to ten), set by the run stage peeling one run per cycle
// reset: synchronous active low, clears all valid bits and loads the register
//   defaults (no parity, one stop bit, one tick per half bit)

module uart_frame_run_length_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  uflre_pkg::in_word_t                 in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output uflre_pkg::out_word_t                out_word,
  input  logic                                cfg_we,
  input  logic [uflre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uflre_pkg::CFG_W-1:0]         cfg_data
);

  logic [1:0]                    parity_r;
  logic [1:0]                    stop_r;
  logic [uflre_pkg::TICKS_W-1:0] ticks_r;
  uflre_pkg::cfg_t               cfg;

  logic              frame_valid;
  logic              frame_ready;
  uflre_pkg::frame_t frame;
  logic              run_valid;
  logic              run_take;
  uflre_pkg::run_t   run;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= uflre_pkg::PARITY_NONE;
      stop_r   <= uflre_pkg::STOP_ONE;
      ticks_r  <= uflre_pkg::TICKS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        uflre_pkg::CFG_PARITY: parity_r <= cfg_data[1:0];
        uflre_pkg::CFG_STOP:   stop_r   <= cfg_data[1:0];
        uflre_pkg::CFG_TICKS:  ticks_r  <= cfg_data[uflre_pkg::TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero tick count acts as one
  always_comb begin
    cfg.parity_mode    = parity_r;
    cfg.stop_length    = stop_r;
    cfg.half_bit_ticks = (ticks_r == '0) ? uflre_pkg::TICKS_W'(1) : ticks_r;
  end

  uflre_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  uflre_runs u_runs (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .run_valid   (run_valid),
    .run_take    (run_take),
    .run         (run)
  );

  uflre_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (run_valid),
    .run_take  (run_take),
    .run       (run),
    .ticks     (cfg.half_bit_ticks),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: sv/uflre_checker.sv
// uflre_checker: port-level assertions for the uart frame run-length encoder
// depends on uflre_pkg; bound to uart_frame_run_length_encoder below

module uflre_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input uflre_pkg::out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // every run lasts at least one tick
  a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.duration_ticks != '0)
    else $error("run of zero duration");

  // message end only on the stop run, which is always high
  a_end_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.message_end |-> out_word.frame_last && out_word.line_level)
    else $error("message end off the high stop run");

  // a frame opens low: a run after a stop run is low
  a_open_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_word.frame_last ##1 out_valid |-> !out_word.line_level)
    else $error("frame did not open low");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind uart_frame_run_length_encoder uflre_checker u_uflre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: bench/testbench.sv
// testbench: self-checking bench for uart_frame_run_length_encoder, frames random and
// corner bytes under several register settings and checks every run against a predictor
// depends on uflre_pkg and the uart_frame_run_length_encoder module

module testbench;

  // codes the package does not name
  localparam logic [1:0]                     PARITY_SPARE = 2'd3;
  localparam logic [1:0]                     STOP_SPARE   = 2'd3;
  localparam logic [uflre_pkg::CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int                             CYCLE_LIMIT  = 200000;

  // expected run queue plus frame predictor
  class frame_run_board;
    uflre_pkg::out_word_t expected_runs[$];
    int           errors = 0;
    logic [1:0]   parity_mode = uflre_pkg::PARITY_NONE;
    logic [1:0]   stop_length = uflre_pkg::STOP_ONE;
    logic [15:0]  half_bit_ticks = 16'd1;
    logic         run_level[16];
    int           run_units[16];
    int           run_count;

    function void write_reg(logic [uflre_pkg::CFG_IDX_W-1:0] idx,
                            logic [uflre_pkg::CFG_W-1:0] data);
      case (idx)
        uflre_pkg::CFG_PARITY: parity_mode = data[1:0];
        uflre_pkg::CFG_STOP:   stop_length = data[1:0];
        uflre_pkg::CFG_TICKS:  half_bit_ticks = data[15:0];
        default: ;
      endcase
    endfunction

    // merge a bit into the current run when the level matches
    function void extend_run(logic level, int units);
      if (run_count > 0 && run_level[run_count-1] == level) begin
        run_units[run_count-1] += units;
      end else begin
        run_level[run_count] = level;
        run_units[run_count] = units;
        run_count++;
      end
    endfunction

    // frame one accepted word and queue its runs
    function void note_byte(uflre_pkg::in_word_t w);
      logic        ones;
      logic        b;
      logic [31:0] ticks;
      logic [31:0] prod;
      int          stop_units;
      uflre_pkg::out_word_t e;
      ones = 1'b0;
      run_count = 0;
      ticks = (half_bit_ticks == 16'd0) ? 32'd1 : {16'd0, half_bit_ticks};
      extend_run(1'b0, 2);
      for (int j = 0; j < uflre_pkg::DATA_BITS; j++) begin
        b = (j < 8) ? w.data_byte[j] : 1'b0;
        ones ^= b;
        extend_run(b, 2);
      end
      if (parity_mode == uflre_pkg::PARITY_EVEN) begin
        extend_run(ones, 2);
      end else if (parity_mode == uflre_pkg::PARITY_ODD) begin
        extend_run(~ones, 2);
      end
      if (stop_length == uflre_pkg::STOP_ONE_HALF) begin
        stop_units = 3;
      end else if (stop_length == uflre_pkg::STOP_TWO) begin
        stop_units = 4;
      end else begin
        stop_units = 2;
      end
      extend_run(1'b1, stop_units);
      for (int k = 0; k < run_count; k++) begin
        prod = run_units[k] * ticks;
        e.line_level     = run_level[k];
        e.duration_ticks = prod[uflre_pkg::DUR_W-1:0];
        e.frame_last     = (k == run_count - 1);
        e.message_end    = e.frame_last & w.last_byte;
        expected_runs.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one accepted run with the oldest expectation
    task check_run(uflre_pkg::out_word_t got);
      uflre_pkg::out_word_t e;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected run level %0d ticks %0d", got.line_level,
                         got.duration_ticks));
      end else begin
        e = expected_runs.pop_front();
        if (got.line_level !== e.line_level)
          report($sformatf("line_level %0d, expected %0d", got.line_level, e.line_level));
        if (got.duration_ticks !== e.duration_ticks)
          report($sformatf("duration_ticks %0d, expected %0d", got.duration_ticks,
                           e.duration_ticks));
        if (got.frame_last !== e.frame_last)
          report($sformatf("frame_last %0d, expected %0d", got.frame_last, e.frame_last));
        if (got.message_end !== e.message_end)
          report($sformatf("message_end %0d, expected %0d", got.message_end,
                           e.message_end));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  uflre_pkg::in_word_t             in_word = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  uflre_pkg::out_word_t            out_word;
  logic                            cfg_we = 1'b0;
  logic [uflre_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [uflre_pkg::CFG_W-1:0]     cfg_data = '0;
  bit                              idle_on = 1'b1;
  int                              cycles = 0;
  frame_run_board                  board = new();

  uart_frame_run_length_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** uart_frame_run_length_encoder: FAILED **");
      $finish;
    end
  end

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 5) : 0;
  endfunction

  // offer one word, called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] data, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word.data_byte <= data;
    in_word.last_byte <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_byte(in_word);
    @(negedge clk);
  endtask

  // one register write per cycle, the caller drops cfg_we afterwards
  task automatic write_reg(logic [uflre_pkg::CFG_IDX_W-1:0] idx,
                           logic [uflre_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_config(logic [uflre_pkg::CFG_W-1:0] parity,
                            logic [uflre_pkg::CFG_W-1:0] stop,
                            logic [uflre_pkg::CFG_W-1:0] ticks);
    write_reg(uflre_pkg::CFG_PARITY, parity);
    write_reg(uflre_pkg::CFG_STOP, stop);
    write_reg(uflre_pkg::CFG_TICKS, ticks);
    cfg_we <= 1'b0;
  endtask

  // wait until every run has come back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_runs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_run(out_word);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [15:0] p;
    logic [15:0] s;
    logic [15:0] t;
    logic [7:0]  d;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: no parity, one stop bit, one tick
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    settle();

    // even parity, one and a half stop bits, zero tick count
    set_config(uflre_pkg::CFG_W'(uflre_pkg::PARITY_EVEN),
               uflre_pkg::CFG_W'(uflre_pkg::STOP_ONE_HALF), 16'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h03, 1'b0);
    settle();

    // odd parity, two stop bits, widest tick count: longest run
    set_config(uflre_pkg::CFG_W'(uflre_pkg::PARITY_ODD),
               uflre_pkg::CFG_W'(uflre_pkg::STOP_TWO), 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h81, 1'b1);
    settle();

    // unused parity and stop codes with junk in the upper data bits
    write_reg(CFG_SPARE, 16'hA5A5);
    set_config({14'h3FFF, PARITY_SPARE}, {14'h3FFF, STOP_SPARE}, 16'h5A5A);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    settle();

    set_config(uflre_pkg::CFG_W'(uflre_pkg::PARITY_EVEN),
               uflre_pkg::CFG_W'(uflre_pkg::STOP_ONE), 16'd1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b0);
    settle();

    // random settings and bytes, idling off in every third phase
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3 != 2);
      p = 16'($urandom_range(0, 3));
      s = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) p[15:2] = 14'($urandom);
      if ($urandom_range(0, 3) == 0) s[15:2] = 14'($urandom);
      case ($urandom_range(0, 4))
        0: t = 16'd0;
        1: t = 16'hFFFF;
        2: t = 16'($urandom_range(1, 8));
        default: t = 16'($urandom_range(1, 65535));
      endcase
      set_config(p, s, t);
      for (int i = 0; i < 35; i++) begin
        case ($urandom_range(0, 9))
          0: d = 8'h00;
          1: d = 8'hFF;
          default: d = 8'($urandom_range(0, 255));
        endcase
        send_byte(d, $urandom_range(0, 3) == 0);
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (board.errors == 0) begin
      $display("** uart_frame_run_length_encoder: PASSED **");
    end else begin
      $display("** uart_frame_run_length_encoder: FAILED **");
    end
    $finish;
  end

endmodule
